// File: rtl/dll_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dll_pkg - shared types for the positional list
// Command and status codes and the control token that walks the cell chain.
// ----------------------------------------------------------------------------
package dll_pkg;

  // default sizes
  localparam int unsigned POOL_DEPTH_DEF = 16;
  localparam int unsigned VALUE_BITS_DEF = 32;

  // fixed field widths
  localparam int unsigned POS_W    = 5;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned LENGTH_W = 5;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_DELETE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  // control part of the token handed from cell to cell
  typedef struct packed {
    logic             vld;       // token present
    cmd_e             cmd;       // operation carried
    logic             shifting;  // delete: target cell already passed
    logic [POS_W-1:0] cnt;       // cells left before the target
    logic             dvld;      // insert: carried data is a live element
  } tok_t;

endpackage

// File: rtl/positional_doubly_linked_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_doubly_linked_list - ordered list of signed values
// Insert at and delete from 1-based positions in a bounded element store.
// ----------------------------------------------------------------------------
// Usage:
//   A command transfers at a rising edge with start high and busy low:
//   command_i (0 insert, 1 delete), position_i and value_in_i.
//   Each command gives one result on status_o, removed_value_o and
//   list_length_o, valid for exactly one cycle while done_o is high.
//   A rejected command (bad position, empty list or full store) answers in
//   the cycle after its transfer and busy stays low. An accepted command
//   sends a token through the chain of POOL_DEPTH cells, one cell a cycle,
//   and answers from the result registers once the token leaves the last
//   cell; busy is high until that result cycle. No new command is taken
//   while one is in the chain; the next may transfer at the edge that ends
//   its predecessor's result cycle.
//   Reset empties the list at once. The receiver cannot stall: results are
//   presented once and not held.
// ----------------------------------------------------------------------------
module positional_doubly_linked_list #(
  parameter int unsigned POOL_DEPTH = dll_pkg::POOL_DEPTH_DEF,
  parameter int unsigned VALUE_BITS = dll_pkg::VALUE_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 command_i,
  input  logic        [dll_pkg::POS_W-1:0]     position_i,
  input  logic signed [dll_pkg::VALUE_W-1:0]   value_in_i,
  output logic                                 done_o,
  output logic        [1:0]                    status_o,
  output logic signed [dll_pkg::VALUE_W-1:0]   removed_value_o,
  output logic        [dll_pkg::LENGTH_W-1:0]  list_length_o
);
  import dll_pkg::*;

  localparam int unsigned CNT_W = $clog2(POOL_DEPTH + 1);
  localparam int unsigned CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  // chain wiring, one slot per cell plus one extra at the end
  tok_t                  tok_w   [POOL_DEPTH+1];
  logic [VALUE_BITS-1:0] data_w  [POOL_DEPTH+1];
  logic                  valid_w [POOL_DEPTH+1];
  logic [VALUE_BITS-1:0] value_w [POOL_DEPTH+1];

  logic                    busy_q;
  logic [CNT_W-1:0]        count_q, count_d;
  tok_t                    inj_q, inj_d;
  logic [VALUE_BITS-1:0]   inj_data_q;
  logic                    done_q, done_d;
  status_e                 status_q, status_d;
  logic signed [VALUE_W-1:0] removed_q, removed_d;

  logic                    accept, is_del, bad_pos, pool_full, launch;
  logic [CMP_W-1:0]        pos_ext, len_ext;
  logic signed [VALUE_BITS-1:0] value_ext;
  logic signed [VALUE_BITS-1:0] end_data;
  tok_t                    tok_end;

  // command checks
  assign accept    = start && !busy_q;
  assign is_del    = (cmd_e'(command_i) == CMD_DELETE);
  assign pos_ext   = CMP_W'(position_i);
  assign len_ext   = CMP_W'(count_q);
  assign bad_pos   = (position_i == '0) ||
                     (is_del ? (pos_ext > len_ext) : (pos_ext > CMP_W'(len_ext + 1'b1)));
  assign pool_full = !is_del && (count_q == CNT_W'(POOL_DEPTH));
  assign launch    = accept && !bad_pos && !pool_full;
  assign value_ext = VALUE_BITS'(value_in_i);

  // token injection and length
  always_comb begin
    inj_d          = '0;
    inj_d.vld      = launch;
    inj_d.cmd      = cmd_e'(command_i);
    inj_d.shifting = 1'b0;
    inj_d.cnt      = POS_W'(position_i - 1'b1);
    inj_d.dvld     = 1'b1;
    count_d        = count_q;
    if (launch) begin
      count_d = is_del ? CNT_W'(count_q - 1'b1) : CNT_W'(count_q + 1'b1);
    end
  end

  assign tok_end  = tok_w[POOL_DEPTH];
  assign end_data = data_w[POOL_DEPTH];

  // result formation
  always_comb begin
    done_d    = 1'b0;
    status_d  = ST_DONE;
    removed_d = '0;
    if (tok_end.vld) begin
      done_d = 1'b1;
      if (tok_end.cmd == CMD_DELETE) begin
        removed_d = VALUE_W'(end_data);
      end
    end else if (accept && !launch) begin
      done_d   = 1'b1;
      status_d = bad_pos ? ST_INVALID : ST_FULL;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      count_q  <= '0;
      inj_q    <= '0;
      done_q   <= 1'b0;
      status_q <= ST_DONE;
    end else begin
      if (launch) begin
        busy_q <= 1'b1;
      end else if (tok_end.vld) begin
        busy_q <= 1'b0;
      end
      count_q  <= count_d;
      inj_q    <= inj_d;
      done_q   <= done_d;
      status_q <= status_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    inj_data_q <= value_ext;
    removed_q  <= removed_d;
  end

  // chain ends
  assign tok_w[0]            = inj_q;
  assign data_w[0]           = inj_data_q;
  assign valid_w[POOL_DEPTH] = 1'b0;
  assign value_w[POOL_DEPTH] = '0;

  // row of cells, list position k+1 lives in cell k
  for (genvar k = 0; k < POOL_DEPTH; k++) begin : g_cell
    dll_cell #(
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .tok_i      (tok_w[k]),
      .data_i     (data_w[k]),
      .nb_valid_i (valid_w[k+1]),
      .nb_value_i (value_w[k+1]),
      .tok_o      (tok_w[k+1]),
      .data_o     (data_w[k+1]),
      .valid_o    (valid_w[k]),
      .value_o    (value_w[k])
    );
  end

  assign busy            = busy_q;
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign removed_value_o = removed_q;
  assign list_length_o   = LENGTH_W'(count_q);

endmodule

// File: rtl/dll_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dll_cell - one element slot of the list chain
// Holds one list element in order and passes the operation token to its
// right neighbor each cycle, shifting elements as the token goes by.
// ----------------------------------------------------------------------------
module dll_cell #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dll_pkg::tok_t         tok_i,
  input  logic [VALUE_BITS-1:0] data_i,
  input  logic                  nb_valid_i,
  input  logic [VALUE_BITS-1:0] nb_value_i,
  output dll_pkg::tok_t         tok_o,
  output logic [VALUE_BITS-1:0] data_o,
  output logic                  valid_o,
  output logic [VALUE_BITS-1:0] value_o
);
  import dll_pkg::*;

  tok_t                  tok_q, tok_d;
  logic [VALUE_BITS-1:0] data_q, data_d;
  logic                  valid_q, valid_d;
  logic [VALUE_BITS-1:0] value_q, value_d;

  // token action at this cell
  always_comb begin
    tok_d   = tok_i;
    data_d  = data_i;
    valid_d = valid_q;
    value_d = value_q;
    if (tok_i.vld) begin
      if (tok_i.cnt != '0) begin
        // not there yet, count down
        tok_d.cnt = POS_W'(tok_i.cnt - 1'b1);
      end else if (tok_i.cmd == CMD_INSERT) begin
        // take the carried element, hand the old one on
        value_d  = data_i;
        valid_d  = tok_i.dvld;
        data_d   = value_q;
        tok_d.dvld = valid_q;
      end else begin
        // pull the right neighbor in, first hit yields the removed element
        value_d = nb_value_i;
        valid_d = nb_valid_i;
        if (!tok_i.shifting) begin
          data_d         = value_q;
          tok_d.shifting = 1'b1;
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      tok_q   <= tok_d;
      valid_q <= valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    data_q  <= data_d;
    value_q <= value_d;
  end

  assign tok_o   = tok_q;
  assign data_o  = data_q;
  assign valid_o = valid_q;
  assign value_o = value_q;

endmodule

// File: sim/positional_doubly_linked_list_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_doubly_linked_list_test - self-checking bench for the list
// Drives insert and delete commands at chosen and random positions, keeps a
// queue-based image of the list to work out status, removed value and length
// for every command, and compares each result strobe against it in order.
// ----------------------------------------------------------------------------
module positional_doubly_linked_list_test;
  import dll_pkg::*;

  localparam int unsigned DEPTH       = POOL_DEPTH_DEF;
  localparam int unsigned DRAIN_WAIT  = DEPTH + 4;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct {
    status_e                   status;
    logic signed [VALUE_W-1:0] removed;
    logic [LENGTH_W-1:0]       length;
  } list_result_t;

  // dut signals, inputs known from time zero
  logic                      clk_i      = 1'b0;
  logic                      rst_ni     = 1'b0;
  logic                      start      = 1'b0;
  logic                      busy;
  logic                      command_i  = 1'b0;
  logic [POS_W-1:0]          position_i = '0;
  logic signed [VALUE_W-1:0] value_in_i = '0;
  logic                      done_o;
  logic [1:0]                status_o;
  logic signed [VALUE_W-1:0] removed_value_o;
  logic [LENGTH_W-1:0]       list_length_o;

  // list image and pending results
  logic signed [VALUE_W-1:0] list_vals[$];
  list_result_t              expected_results[$];

  int unsigned cycle_count  = 0;
  int unsigned error_count  = 0;
  int unsigned insert_count = 0;
  int unsigned delete_count = 0;
  int unsigned invalid_count = 0;
  int unsigned full_count   = 0;
  int unsigned peak_length  = 0;
  bit          sender_idles = 1'b1;

  positional_doubly_linked_list u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .command_i       (command_i),
    .position_i      (position_i),
    .value_in_i      (value_in_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .removed_value_o (removed_value_o),
    .list_length_o   (list_length_o)
  );

  // clock
  always #5 clk_i = ~clk_i;

  // run time limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("positional_doubly_linked_list_test: errors");
      $finish;
    end
  end

  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  // apply one command to the list image and return what the block should say
  function automatic list_result_t list_apply(input cmd_e cmd, input int pos,
                                              input logic signed [VALUE_W-1:0] val);
    list_result_t res;
    int           len;
    len         = list_vals.size();
    res.status  = ST_DONE;
    res.removed = '0;
    if (cmd == CMD_INSERT) begin
      if (pos == 0 || pos > len + 1) begin
        res.status = ST_INVALID;
      end else if (len >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        list_vals.insert(pos - 1, val);
      end
    end else begin
      if (pos == 0 || pos > len) begin
        res.status = ST_INVALID;
      end else begin
        res.removed = list_vals[pos - 1];
        list_vals.delete(pos - 1);
      end
    end
    res.length = LENGTH_W'(list_vals.size());
    return res;
  endfunction

  // one command transfer, with a random lead-in gap while sender_idles is set
  task automatic send_cmd(input cmd_e cmd, input int pos,
                          input logic signed [VALUE_W-1:0] val);
    int unsigned  gap;
    list_result_t res;
    gap = sender_idles ? $urandom_range(0, 12) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start      <= 1'b1;
    command_i  <= cmd;
    position_i <= POS_W'(pos);
    value_in_i <= val;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    // transfer happened at this edge
    res = list_apply(cmd, pos, val);
    expected_results.push_back(res);
    case (res.status)
      ST_DONE: begin
        if (cmd == CMD_INSERT) insert_count++;
        else delete_count++;
      end
      ST_FULL: full_count++;
      default: invalid_count++;
    endcase
    if (list_vals.size() > peak_length) peak_length = list_vals.size();
  endtask

  // hold off the sender until every result is in
  task automatic wait_for_drain();
    start <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
  endtask

  // result checker
  always @(posedge clk_i) begin : check_results
    list_result_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (expected_results.size() == 0) begin
        note_error($sformatf("result with nothing pending: status %0d removed %0d len %0d",
                             status_o, removed_value_o, list_length_o));
      end else begin
        want = expected_results.pop_front();
        if (status_o !== want.status)
          note_error($sformatf("status exp %0d got %0d", want.status, status_o));
        if (removed_value_o !== want.removed)
          note_error($sformatf("removed_value exp %0d got %0d", want.removed,
                               removed_value_o));
        if (list_length_o !== want.length)
          note_error($sformatf("list_length exp %0d got %0d", want.length,
                               list_length_o));
      end
    end
  end

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return VALUE_W'($signed($urandom_range(0, 32)) - 16);
      default: return $urandom;
    endcase
  endfunction

  // mostly in-range positions, some anywhere in the field
  function automatic int pick_pos(input cmd_e cmd);
    int len;
    len = list_vals.size();
    if ($urandom_range(0, 9) < 2) return $urandom_range(0, 31);
    if (cmd == CMD_INSERT) return $urandom_range(1, len + 1);
    return (len == 0) ? 1 : $urandom_range(1, len);
  endfunction

  // ends, middle, position zero and past-end cases on a short list
  task automatic test_edges();
    sender_idles = 1'b1;
    send_cmd(CMD_DELETE, 1, 32'sd5);
    send_cmd(CMD_DELETE, 0, 32'sd0);
    send_cmd(CMD_INSERT, 0, 32'sd7);
    send_cmd(CMD_INSERT, 2, 32'sd7);
    send_cmd(CMD_INSERT, 1, 32'h7fff_ffff);
    send_cmd(CMD_INSERT, 2, 32'h8000_0000);
    send_cmd(CMD_INSERT, 1, 32'sd0);
    send_cmd(CMD_INSERT, 2, -32'sd1);
    send_cmd(CMD_INSERT, 5, 32'sd1);
    send_cmd(CMD_INSERT, 7, 32'sd3);
    send_cmd(CMD_INSERT, 31, 32'sd3);
    send_cmd(CMD_DELETE, 6, 32'sd0);
    send_cmd(CMD_DELETE, 31, 32'sd0);
    send_cmd(CMD_DELETE, 5, 32'sd0);
    send_cmd(CMD_DELETE, 1, 32'sd0);
    send_cmd(CMD_DELETE, 2, 32'sd0);
    send_cmd(CMD_INSERT, 2, 32'h5555_5555);
    send_cmd(CMD_INSERT, 1, 32'haaaa_aaaa);
    while (list_vals.size() != 0) send_cmd(CMD_DELETE, 1, 32'sd0);
    send_cmd(CMD_DELETE, 1, 32'sd0);
  endtask

  // fill the store, hit the full and bad-position checks, then empty it
  task automatic test_full_pool();
    sender_idles = 1'b0;
    while (list_vals.size() < DEPTH)
      send_cmd(CMD_INSERT, $urandom_range(1, list_vals.size() + 1), pick_value());
    sender_idles = 1'b1;
    send_cmd(CMD_INSERT, DEPTH + 1, 32'sd9);
    send_cmd(CMD_INSERT, 1, 32'sd9);
    send_cmd(CMD_INSERT, 0, 32'sd9);
    send_cmd(CMD_INSERT, DEPTH + 2, 32'sd9);
    send_cmd(CMD_INSERT, 31, 32'sd9);
    send_cmd(CMD_DELETE, DEPTH + 1, 32'sd0);
    send_cmd(CMD_DELETE, DEPTH, 32'sd0);
    while (list_vals.size() != 0)
      send_cmd(CMD_DELETE, $urandom_range(1, list_vals.size()), pick_value());
    send_cmd(CMD_DELETE, 1, 32'sd0);
  endtask

  // blocks that lean toward growing or shrinking so every length is visited
  task automatic test_random_mix();
    cmd_e cmd;
    bit   grow;
    for (int blk = 0; blk < 14; blk++) begin
      sender_idles = ($urandom_range(0, 3) != 0);
      grow         = (blk % 2 == 0);
      if (blk == 7) wait_for_drain();
      for (int n = 0; n < 100; n++) begin
        if (grow) cmd = ($urandom_range(0, 9) < 7) ? CMD_INSERT : CMD_DELETE;
        else      cmd = ($urandom_range(0, 9) < 7) ? CMD_DELETE : CMD_INSERT;
        send_cmd(cmd, pick_pos(cmd), pick_value());
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_edges();
    test_full_pool();
    test_random_mix();

    // let the last results come in
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("covered %0d inserts, %0d deletes, %0d bad-position or empty, %0d full",
             insert_count, delete_count, invalid_count, full_count);
    $display("peak list length %0d, %0d mismatches in %0d cycles", peak_length,
             error_count, cycle_count);
    if (error_count == 0) begin
      $display("positional_doubly_linked_list_test: clean");
    end else begin
      $display("positional_doubly_linked_list_test: errors");
    end
    $finish;
  end

endmodule
